// File: hdl/rpn_pkg.sv
package rpn_pkg;

	localparam int IN_W = 40;
	localparam int OUT_W = 48;
	localparam int DATA_W = 32;
	localparam int OPCODE_W = 3;
	localparam int STATUS_W = 2;
	localparam int COUNT_W = 7;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

	localparam logic [OPCODE_W-1:0] OP_PUSH = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_ADD = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_SUB = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_MUL = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_DIV = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FEW = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

	typedef enum logic [2:0] {
		KIND_PUSH,
		KIND_ADD,
		KIND_SUB,
		KIND_MUL,
		KIND_DIV,
		KIND_NOP
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [DATA_W-1:0] operand;
	} cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CALC,
		S_DIVIDE,
		S_FINISH
	} exec_state_t;

endpackage

// File: hdl/rpn_front.sv
module rpn_front (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// opcode [2:0], operand [34:3], zero fill [39:35]
	input  logic [rpn_pkg::IN_W-1:0] s_tdata,
	output logic q_valid,
	input  logic q_ready,
	output rpn_pkg::cmd_t q_data
);

	rpn_pkg::cmd_t queue_q [rpn_pkg::QUEUE_DEPTH];
	logic [rpn_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [rpn_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [rpn_pkg::QUEUE_CW-1:0] fill_q;
	rpn_pkg::cmd_t cmd_in;
	logic push;
	logic pop;

	always_comb begin
		cmd_in.operand = s_tdata[rpn_pkg::OPCODE_W +: rpn_pkg::DATA_W];
		case (s_tdata[rpn_pkg::OPCODE_W-1:0])
			rpn_pkg::OP_PUSH: cmd_in.kind = rpn_pkg::KIND_PUSH;
			rpn_pkg::OP_ADD: cmd_in.kind = rpn_pkg::KIND_ADD;
			rpn_pkg::OP_SUB: cmd_in.kind = rpn_pkg::KIND_SUB;
			rpn_pkg::OP_MUL: cmd_in.kind = rpn_pkg::KIND_MUL;
			rpn_pkg::OP_DIV: cmd_in.kind = rpn_pkg::KIND_DIV;
			default: cmd_in.kind = rpn_pkg::KIND_NOP;
		endcase
	end

	assign s_tready = (fill_q != rpn_pkg::QUEUE_CW'(rpn_pkg::QUEUE_DEPTH));
	assign q_valid = (fill_q != '0);
	assign q_data = queue_q[rd_ptr_q];
	assign push = s_tvalid && s_tready;
	assign pop = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/rpn_div.sv
module rpn_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [rpn_pkg::DATA_W-1:0] dividend,
	input  logic [rpn_pkg::DATA_W-1:0] divisor,
	output logic done,
	output logic [rpn_pkg::DATA_W-1:0] quotient
);

	localparam int W = rpn_pkg::DATA_W;
	localparam int CNT_W = $clog2(W);

	logic busy_q;
	logic done_q;
	logic neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] quo_q;
	logic [W-1:0] dvs_q;
	logic [W:0] rem_sh;
	logic [W:0] diff;
	logic ge;
	logic [W-1:0] mag_a;
	logic [W-1:0] mag_b;

	assign mag_a = dividend[W-1] ? (W'(0) - dividend) : dividend;
	assign mag_b = divisor[W-1] ? (W'(0) - divisor) : divisor;
	assign rem_sh = {rem_q, quo_q[W-1]};
	assign diff = rem_sh - {1'b0, dvs_q};
	assign ge = (rem_sh >= {1'b0, dvs_q});
	assign done = done_q;
	assign quotient = neg_q ? (W'(0) - quo_q) : quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= mag_a;
			dvs_q <= mag_b;
			neg_q <= dividend[W-1] ^ divisor[W-1];
		end else if (busy_q) begin
			rem_q <= ge ? diff[W-1:0] : rem_sh[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// File: hdl/rpn_exec.sv
module rpn_exec #(
	parameter int STACK_DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	output logic q_ready,
	input  rpn_pkg::cmd_t q_data,
	output logic m_tvalid,
	input  logic m_tready,
	// status [1:0], result_value [33:2], stack_count [40:34], zero fill [47:41]
	output logic [rpn_pkg::OUT_W-1:0] m_tdata
);

	localparam int W = rpn_pkg::DATA_W;
	localparam int SP_W = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);
	localparam logic [SP_W-1:0] SP_ONE = SP_W'(1);
	localparam logic [SP_W-1:0] SP_TWO = SP_W'(2);

	logic [W-1:0] stack_mem [STACK_DEPTH];

	rpn_pkg::exec_state_t state_q, state_d;
	rpn_pkg::cmd_t cmd_q, cmd_d;
	logic [SP_W-1:0] sp_q, sp_d;
	logic [W-1:0] right_q;
	logic [W-1:0] left_q;
	logic [W-1:0] res_q, res_d;
	logic [rpn_pkg::STATUS_W-1:0] status_q, status_d;
	logic commit_q, commit_d;
	logic m_valid_q, m_valid_d;
	logic [rpn_pkg::STATUS_W-1:0] out_status_q, out_status_d;
	logic [W-1:0] out_value_q, out_value_d;
	logic [rpn_pkg::COUNT_W-1:0] out_count_q, out_count_d;

	logic mem_we;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr_r;
	logic [AW-1:0] rd_addr_l;
	logic div_start;
	logic div_done;
	logic [W-1:0] div_quot;

	rpn_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(left_q),
		.divisor(right_q),
		.done(div_done),
		.quotient(div_quot)
	);

	assign rd_addr_r = AW'(sp_q - SP_ONE);
	assign rd_addr_l = AW'(sp_q - SP_TWO);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[wr_addr] <= res_q;
		end
		right_q <= stack_mem[rd_addr_r];
		left_q <= stack_mem[rd_addr_l];
	end

	always_comb begin
		state_d = state_q;
		cmd_d = cmd_q;
		sp_d = sp_q;
		res_d = res_q;
		status_d = status_q;
		commit_d = commit_q;
		m_valid_d = m_valid_q && !m_tready;
		out_status_d = out_status_q;
		out_value_d = out_value_q;
		out_count_d = out_count_q;
		q_ready = 1'b0;
		mem_we = 1'b0;
		wr_addr = AW'(sp_q);
		div_start = 1'b0;
		case (state_q)
			rpn_pkg::S_IDLE: begin
				if (q_valid) begin
					q_ready = 1'b1;
					cmd_d = q_data;
					status_d = rpn_pkg::ST_OK;
					res_d = '0;
					commit_d = 1'b0;
					state_d = rpn_pkg::S_FINISH;
					case (q_data.kind)
						rpn_pkg::KIND_PUSH: begin
							if (sp_q == SP_FULL) begin
								status_d = rpn_pkg::ST_FULL;
							end else begin
								res_d = q_data.operand;
								commit_d = 1'b1;
							end
						end
						rpn_pkg::KIND_NOP: begin
							status_d = rpn_pkg::ST_OK;
						end
						default: begin
							if (sp_q < SP_TWO) begin
								status_d = rpn_pkg::ST_FEW;
							end else begin
								state_d = rpn_pkg::S_CALC;
							end
						end
					endcase
				end
			end
			rpn_pkg::S_CALC: begin
				state_d = rpn_pkg::S_FINISH;
				commit_d = 1'b1;
				case (cmd_q.kind)
					rpn_pkg::KIND_ADD: res_d = left_q + right_q;
					rpn_pkg::KIND_SUB: res_d = left_q - right_q;
					rpn_pkg::KIND_MUL: res_d = left_q * right_q;
					rpn_pkg::KIND_DIV: begin
						if (right_q == '0) begin
							status_d = rpn_pkg::ST_DIVZERO;
							res_d = '0;
							commit_d = 1'b0;
						end else begin
							div_start = 1'b1;
							state_d = rpn_pkg::S_DIVIDE;
						end
					end
					default: commit_d = 1'b0;
				endcase
			end
			rpn_pkg::S_DIVIDE: begin
				if (div_done) begin
					res_d = div_quot;
					state_d = rpn_pkg::S_FINISH;
				end
			end
			rpn_pkg::S_FINISH: begin
				if (!m_valid_q || m_tready) begin
					if (commit_q) begin
						mem_we = 1'b1;
						if (cmd_q.kind == rpn_pkg::KIND_PUSH) begin
							wr_addr = AW'(sp_q);
							sp_d = sp_q + SP_ONE;
						end else begin
							wr_addr = AW'(sp_q - SP_TWO);
							sp_d = sp_q - SP_ONE;
						end
					end
					m_valid_d = 1'b1;
					out_status_d = status_q;
					out_value_d = res_q;
					out_count_d = rpn_pkg::COUNT_W'(sp_d);
					state_d = rpn_pkg::S_IDLE;
				end
			end
			default: state_d = rpn_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		cmd_q <= cmd_d;
		res_q <= res_d;
		status_q <= status_d;
		commit_q <= commit_d;
		out_status_q <= out_status_d;
		out_value_q <= out_value_d;
		out_count_q <= out_count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpn_pkg::S_IDLE;
			sp_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sp_q <= sp_d;
			m_valid_q <= m_valid_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {
		(rpn_pkg::OUT_W - rpn_pkg::COUNT_W - W - rpn_pkg::STATUS_W)'(0),
		out_count_q,
		out_value_q,
		out_status_q
	};

endmodule

// File: hdl/rpn_stack_calculator_unit.sv
// Reverse Polish integer calculator on an operand stack of STACK_DEPTH words.
// Each input word carries an opcode (push, add, subtract, multiply, divide)
// and a signed operand, and yields exactly one output word with a status,
// the value pushed (zero on error) and the stack depth after the item.
// Input words enter a four-entry queue, so the sender sees tready high
// while the queue has room, even while the execution side is busy.
// Items are executed one at a time because each depends on the stack the
// previous one left. A push, an unknown opcode or an error found at decode
// goes from the idle state straight to the finish state, which loads the
// output register; add, subtract and multiply pass through the calc state
// first, and divide then waits in the divide state for the 32-step divider,
// which forms one quotient bit per cycle. New items are taken only in idle.
// The result sits in an output register; while the receiver holds tready low
// the finished word waits there, execution stops at the next result, and the
// queue keeps accepting input until it is full.
// Reset clears the queue, the stack depth and the output valid; stack
// contents are not cleared, and their values are used only after they are written.
module rpn_stack_calculator_unit #(
	parameter int STACK_DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// opcode [2:0], operand [34:3], zero fill [39:35]
	input  logic [rpn_pkg::IN_W-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// status [1:0], result_value [33:2], stack_count [40:34], zero fill [47:41]
	output logic [rpn_pkg::OUT_W-1:0] m_tdata
);

	logic q_valid;
	logic q_ready;
	rpn_pkg::cmd_t q_data;

	rpn_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.q_data(q_data)
	);

	rpn_exec #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_exec (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.q_data(q_data),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

endmodule
